// ===== rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; every other file imports this package.
package ple_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_ple_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [8:0]               count;
        logic [1:0]               status;
    } t_ple_out;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_ple_mem_req;

endpackage

// ===== rtl/ple_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on ple_pkg for the request struct.
module ple_ram
    import ple_pkg::*;
#(
    parameter int DEPTH = CAPACITY,
    parameter int WIDTH = DATA_W
) (
    input  logic               i_clk,
    input  t_ple_mem_req       i_req,
    output logic [WIDTH-1:0]   o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= WIDTH'(i_req.wr_data);
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ple_ctrl.sv =====
// Sequencer for the list engine: walks the entry memory to shift entries.
// Depends on ple_pkg; drives the request port of ple_ram.
module ple_ctrl
    import ple_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_ple_in           i_item,
    input  logic              i_take,
    input  logic [DATA_W-1:0] i_rdata,
    output logic              o_busy,
    output logic              o_res_valid,
    output t_ple_out          o_res,
    output t_ple_mem_req      o_req
);

    typedef enum logic [2:0] {
        S_IDLE, S_INS, S_INS_LAST, S_RM_HEAD, S_RM, S_RD, S_DONE
    } t_state;

    t_state            r_state,  n_state;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [ADDR_W-1:0] r_addr,   n_addr;
    logic [ADDR_W-1:0] r_lim,    n_lim;
    logic [DATA_W-1:0] r_val,    n_val;
    t_ple_out          r_res,    n_res;
    t_ple_mem_req      req;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;

    assign pos_ext = CMP_W'(i_item.position);
    assign cnt_ext = CMP_W'(r_count);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_addr  = r_addr;
        n_lim   = r_lim;
        n_val   = r_val;
        n_res   = r_res;
        req     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_res.value_out = '0;
                    n_res.count     = 9'(r_count);
                    n_res.status    = ST_OK;
                    n_val           = DATA_W'(i_item.value);
                    n_state         = S_DONE;
                    case (i_item.mode)
                        MODE_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_res.status = ST_FULL;
                            end else if (pos_ext >= cnt_ext) begin
                                // append: no shift needed
                                req.wr_en    = 1'b1;
                                req.wr_addr  = ADDR_W'(r_count);
                                req.wr_data  = DATA_W'(i_item.value);
                                n_count      = r_count + CNT_W'(1);
                                n_res.count  = 9'(n_count);
                            end else begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = ADDR_W'(r_count - CNT_W'(1));
                                n_addr      = ADDR_W'(r_count - CNT_W'(1));
                                n_lim       = ADDR_W'(pos_ext);
                                n_state     = S_INS;
                            end
                        end
                        MODE_REMOVE, MODE_READ: begin
                            if (pos_ext >= cnt_ext) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                req.rd_en   = 1'b1;
                                req.rd_addr = ADDR_W'(pos_ext);
                                n_addr      = ADDR_W'(pos_ext);
                                n_lim       = ADDR_W'(r_count - CNT_W'(1));
                                n_state     = (i_item.mode == MODE_READ) ? S_RD : S_RM_HEAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_INS: begin
                // move entry one place back, walk towards the head
                req.wr_en   = 1'b1;
                req.wr_addr = r_addr + ADDR_W'(1);
                req.wr_data = i_rdata;
                if (r_addr == r_lim) begin
                    n_state = S_INS_LAST;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_addr - ADDR_W'(1);
                    n_addr      = r_addr - ADDR_W'(1);
                end
            end
            S_INS_LAST: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_lim;
                req.wr_data = r_val;
                n_count     = r_count + CNT_W'(1);
                n_res.count = 9'(n_count);
                n_state     = S_DONE;
            end
            S_RM_HEAD: begin
                n_res.value_out = i_rdata;
                if (r_addr == r_lim) begin
                    n_count     = r_count - CNT_W'(1);
                    n_res.count = 9'(n_count);
                    n_state     = S_DONE;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_addr + ADDR_W'(1);
                    n_addr      = r_addr + ADDR_W'(1);
                    n_state     = S_RM;
                end
            end
            S_RM: begin
                // move entry one place forward, walk towards the tail
                req.wr_en   = 1'b1;
                req.wr_addr = r_addr - ADDR_W'(1);
                req.wr_data = i_rdata;
                if (r_addr == r_lim) begin
                    n_count     = r_count - CNT_W'(1);
                    n_res.count = 9'(n_count);
                    n_state     = S_DONE;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_addr + ADDR_W'(1);
                    n_addr      = r_addr + ADDR_W'(1);
                end
            end
            S_RD: begin
                n_res.value_out = i_rdata;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_addr <= n_addr;
        r_lim  <= n_lim;
        r_val  <= n_val;
        r_res  <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_req       = req;

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(req.rd_en && req.wr_en && req.rd_addr == req.wr_addr))
        else $error("read and write hit the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + CNT_W'(1) ||
                            r_count == $past(r_count) - CNT_W'(1)))
        else $error("entry count moved by more than one");

endmodule

// ===== rtl/positional_list_engine.sv =====
// Positional list engine: ordered list of signed words kept in one RAM.
// Throughput: one item at a time; a new beat is taken only once the previous result has moved
// into the output register. The shift walk moves one entry per cycle through the single RAM write port.
// Reset (synchronous, active low) empties the list; entry contents are left as they are.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_ple_in  i_in_item,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_ple_out o_out_item
);

    logic              in_accept;
    logic              busy;
    logic              res_valid;
    logic              take;
    t_ple_out          res;
    t_ple_mem_req      mem_req;
    logic [DATA_W-1:0] mem_rdata;

    logic              r_out_valid;
    t_ple_out          r_out;

    // Take a new beat only while the sequencer is idle.
    assign o_in_stall = busy;
    assign in_accept  = i_in_valid && !busy;

    // Move a finished result into the output register when it is free or draining.
    assign take = res_valid && (!r_out_valid || !i_out_stall);

    ple_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_item),
        .i_take      (take),
        .i_rdata     (mem_rdata),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_req       (mem_req)
    );

    ple_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Output register: hold the beat while stalled, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for positional_list_engine: directed, fill/drain, random and
// back-pressure tests against an in-bench list predictor. Depends on rtl/ple_pkg.sv and the design files.
`timescale 1ns / 1ps

module testbench;
    import ple_pkg::*;

    // Mode 3 is not named in the package; the block must treat it as a no-op.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 450;
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off in the pressure test
    localparam int TAIL_CYCLES    = 300;   // longest shift walk plus margin
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on either channel
    localparam int PRINT_LIMIT    = 40;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_ple_in  in_item   = '0;
    logic     out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_ple_out o_out_item;

    // Knobs shared between the stimulus and the receiver process.
    logic in_gaps_on    = 1'b1;
    logic out_stalls_on = 1'b1;
    logic hold_request  = 1'b0;

    int mismatches  = 0;
    int beats_seen  = 0;
    int idle_cycles = 0;

    // Predicted list contents and length, plus the replies still owed by the block.
    logic signed [DATA_W-1:0] list_model [CAPACITY];
    int                       list_len = 0;
    t_ple_out                 expected_replies [$];
    t_ple_out                 oldest_reply;

    always #10 clk = ~clk;

    positional_list_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    // ------------------------------------------------------------------
    // Predictor: apply one command to the list and return the reply.
    // ------------------------------------------------------------------
    function automatic t_ple_out apply_to_list(input t_ple_in cmd);
        t_ple_out reply;
        int       pos;
        int       i;
        reply        = '0;
        reply.status = ST_OK;
        pos          = cmd.position;
        case (cmd.mode)
            MODE_INSERT: begin
                if (list_len >= CAPACITY) begin
                    // Full list: refuse the insert and leave everything alone.
                    reply.status = ST_FULL;
                end else begin
                    // Clamp past-the-end positions so that they append.
                    if (pos > list_len) pos = list_len;
                    for (i = list_len; i > pos; i--) list_model[i] = list_model[i - 1];
                    list_model[pos] = cmd.value;
                    list_len++;
                end
            end
            MODE_REMOVE: begin
                if (pos >= list_len) begin
                    reply.status = ST_RANGE;
                end else begin
                    reply.value_out = list_model[pos];
                    for (i = pos; i + 1 < list_len; i++) list_model[i] = list_model[i + 1];
                    list_len--;
                end
            end
            MODE_READ: begin
                if (pos >= list_len) reply.status = ST_RANGE;
                else reply.value_out = list_model[pos];
            end
            default: ;  // unused mode: reply with the count as it stands
        endcase
        reply.count = 9'(list_len);
        return reply;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] MISMATCH beat %0d %s: got %0h, want %0h",
                     $time, beats_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Sender: offer one command, hold it until the block takes it, then
    // record the reply it must produce. Called and returns at a rising edge.
    // ------------------------------------------------------------------
    task automatic issue_command(input logic [1:0] mode, input logic [POS_W-1:0] pos,
                                 input logic signed [DATA_W-1:0] val);
        t_ple_in cmd;
        int      gap;
        cmd.mode     = mode;
        cmd.position = pos;
        cmd.value    = val;
        gap          = in_gaps_on ? draw_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= cmd;
        in_valid <= 1'b1;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        expected_replies.push_back(apply_to_list(cmd));
    endtask

    // Drop valid and wait for every owed reply to come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_replies.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result check: compare each reply beat with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            beats_seen++;
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected beat, value_out", o_out_item.value_out, '0);
            end else begin
                oldest_reply = expected_replies.pop_front();
                if (o_out_item.value_out !== oldest_reply.value_out)
                    report_mismatch("value_out", o_out_item.value_out, oldest_reply.value_out);
                if (o_out_item.count !== oldest_reply.count)
                    report_mismatch("count", 32'(o_out_item.count), 32'(oldest_reply.count));
                if (o_out_item.status !== oldest_reply.status)
                    report_mismatch("status", 32'(o_out_item.status), 32'(oldest_reply.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall runs, plus one long hold-off on request.
    // Each pass makes one assignment and then waits out its run.
    // ------------------------------------------------------------------
    initial begin : receiver
        int run;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                run = HOLD_CYCLES;
            end else if (!out_stalls_on) begin
                out_stall <= 1'b0;
                run = 1;
            end else if ($urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                run = draw_gap() + 1;
            end else begin
                out_stall <= 1'b0;
                run = $urandom_range(1, 8);
            end
            repeat (run) @(posedge clk);
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty-list errors, extremes of every field, clamped appends, the
    // unused mode, and reads/removes at both ends and past the end.
    task automatic test_directed();
        issue_command(MODE_READ,   8'd0,   32'sd0);
        issue_command(MODE_REMOVE, 8'd0,   32'sd0);
        issue_command(MODE_UNUSED, 8'd0,   32'sd0);
        issue_command(MODE_INSERT, 8'd0,   32'sh7FFF_FFFF);
        issue_command(MODE_INSERT, 8'd255, 32'sh8000_0000);  // clamps to an append
        issue_command(MODE_INSERT, 8'd1,   -32'sd1);
        issue_command(MODE_INSERT, 8'd0,   32'sd0);
        issue_command(MODE_INSERT, 8'd200, 32'sh5555_5555);
        issue_command(MODE_INSERT, 8'd2,   32'shAAAA_AAAA);
        issue_command(MODE_READ,   8'd0,   32'sd0);
        issue_command(MODE_READ,   8'd5,   -32'sd1);          // last entry
        issue_command(MODE_READ,   8'd6,   32'sd0);           // one past the end
        issue_command(MODE_READ,   8'd255, 32'sd0);
        issue_command(MODE_UNUSED, 8'd255, -32'sd1);
        issue_command(MODE_REMOVE, 8'd5,   32'sd0);           // tail
        issue_command(MODE_REMOVE, 8'd0,   32'sd0);           // head
        issue_command(MODE_REMOVE, 8'd1,   32'sd0);           // middle
        issue_command(MODE_REMOVE, 8'd200, 32'sd0);           // past the end
        issue_command(MODE_READ,   8'd1,   32'sd0);
        issue_command(MODE_REMOVE, 8'd0,   32'sd0);
        issue_command(MODE_REMOVE, 8'd0,   32'sd0);
        issue_command(MODE_REMOVE, 8'd0,   32'sd0);           // last one out
        issue_command(MODE_READ,   8'd0,   32'sd0);
        wait_for_drain();
    endtask

    // Fill the list to capacity, hit the full case, then empty it again.
    task automatic test_fill_and_drain();
        in_gaps_on    = 1'b1;
        out_stalls_on = 1'b1;
        while (list_len < CAPACITY)
            issue_command(MODE_INSERT, POS_W'($urandom_range(0, 255)), $urandom);
        issue_command(MODE_INSERT, 8'd0,   32'sd1);
        issue_command(MODE_INSERT, 8'd128, 32'sd2);
        issue_command(MODE_INSERT, 8'd255, 32'sd3);
        issue_command(MODE_READ,   8'd255, 32'sd0);
        issue_command(MODE_READ,   8'd0,   32'sd0);
        issue_command(MODE_UNUSED, 8'd17,  32'sd0);
        issue_command(MODE_REMOVE, 8'd255, 32'sd0);
        issue_command(MODE_INSERT, 8'd255, -32'sd1);         // refill by append
        issue_command(MODE_INSERT, 8'd255, 32'sd4);          // full again
        // Drain, one remove in four through the head, to make the shift walks as long as they get.
        out_stalls_on = 1'b0;
        in_gaps_on    = 1'b0;
        while (list_len > 0)
            issue_command(MODE_REMOVE,
                          ($urandom_range(0, 3) == 0) ? 8'd0
                                                      : POS_W'($urandom_range(0, list_len - 1)),
                          $urandom);
        issue_command(MODE_REMOVE, 8'd0, 32'sd0);
        wait_for_drain();
    endtask

    // Random mix in phases that grow, hold or shrink the list, so that it
    // swings between empty and full. Idling on each side changes per phase.
    task automatic test_random_mix();
        int                       n;
        int                       r;
        int                       span;
        int                       grow_pct;
        logic [1:0]               mode;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        grow_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                r             = $urandom_range(0, 2);
                grow_pct      = (r == 0) ? 90 : (r == 1) ? 50 : 15;
                in_gaps_on    = ($urandom_range(0, 3) != 0);
                out_stalls_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3)                                    mode = MODE_UNUSED;
            else if (r < 28)                              mode = MODE_READ;
            else if ($urandom_range(0, 99) < grow_pct)    mode = MODE_INSERT;
            else                                          mode = MODE_REMOVE;
            // Aim mostly inside the list, sometimes at its end, sometimes anywhere.
            span = (mode == MODE_INSERT) ? list_len : ((list_len > 0) ? list_len - 1 : 0);
            if (span > 255) span = 255;
            r = $urandom_range(0, 9);
            if (r < 7)       pos = POS_W'($urandom_range(0, span));
            else if (r == 7) pos = POS_W'(span);
            else             pos = POS_W'($urandom_range(0, 255));
            r = $urandom_range(0, 15);
            if (r == 0)      val = 32'sh7FFF_FFFF;
            else if (r == 1) val = 32'sh8000_0000;
            else             val = $urandom;
            issue_command(mode, pos, val);
        end
        wait_for_drain();
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering beats back to back, so that the block backs up and stalls.
    task automatic test_backpressure();
        int n;
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b1;
        hold_request  = 1'b1;
        for (n = 0; n < 40; n++) begin
            if (n % 2 == 0)
                issue_command(MODE_INSERT, 8'd255, $urandom);
            else
                issue_command(MODE_READ, POS_W'($urandom_range(0, list_len)), $urandom);
        end
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain();
        test_random_mix();
        test_backpressure();

        // Let any stray beat show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_replies.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
dv/testbench.sv
